@@ src/rhls_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rhls_pkg;

   // Number of divider stages; each stage resolves DivBits quotient bits.
   localparam int DivStages = 4;
   localparam int DivBits   = 4;

   // Reset value of the lightness gain (1.0 in unsigned 8.8).
   localparam logic [15:0] GainReset = 16'd256;

   // Byte address of the lightness gain register.
   localparam logic [1:0] CsrGain = 2'd0;

   // Hue ramp breakpoints in units of 1/12288 turn.
   localparam logic [13:0] RampRise = 14'd2048;
   localparam logic [13:0] RampFlat = 14'd6144;
   localparam logic [13:0] RampFall = 14'd8192;
   localparam logic [14:0] HueTurn3 = 15'd12288;
   localparam logic [14:0] HueThird = 15'd4096;

   // Input pixel transaction.
   typedef struct packed {
      logic [7:0] in_red;
      logic [7:0] in_green;
      logic [7:0] in_blue;
   } req_type;

   // Result transaction.
   typedef struct packed {
      logic [11:0] hue;
      logic [11:0] saturation;
      logic [11:0] scaled_lightness;
      logic [7:0]  out_red;
      logic [7:0]  out_green;
      logic [7:0]  out_blue;
   } rsp_type;

   // Restoring divider state: partial remainder, a shift register that holds
   // the remaining dividend bits and collects quotient bits, and the divisor.
   typedef struct packed {
      logic [10:0] rem;
      logic [15:0] shq;
      logic [10:0] dvs;
   } div_type;

   // Weight of q against p for one channel at hue position t.
   function automatic logic [11:0] ramp_weight(input logic [13:0] t);
      logic [13:0] w;
      if (t < RampRise) begin
         w = t;
      end else if (t < RampFlat) begin
         w = RampRise;
      end else if (t < RampFall) begin
         w = RampFall - t;
      end else begin
         w = 14'd0;
      end
      return w[11:0];
   endfunction

endpackage

`default_nettype wire

@@ src/rhls_div_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rhls_div_stage (
   input  wire                   clock,
   input  wire rhls_pkg::div_type div_in,
   output rhls_pkg::div_type     div_out
);

   rhls_pkg::div_type div_out_in;

   // Four restoring steps, one quotient bit each.
   always_comb begin
      logic [11:0] trial;
      div_out_in = div_in;
      for (int i = 0; i < rhls_pkg::DivBits; i++) begin
         trial = {div_out_in.rem, div_out_in.shq[15]};
         div_out_in.shq = {div_out_in.shq[14:0], 1'b0};
         if (trial >= {1'b0, div_out_in.dvs}) begin
            trial = trial - {1'b0, div_out_in.dvs};
            div_out_in.shq[0] = 1'b1;
         end
         div_out_in.rem = trial[10:0];
      end
   end

   // Stage register.
   always_ff @(posedge clock) begin
      div_out <= div_out_in;
   end

endmodule

`default_nettype wire

@@ src/rgb_hsl_lightness_scaler_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel      Ports                               Transfer
// ---------    --------------------------------    --------------------------
// pixel in     start, busy, req_pixel              start high and busy low
// result out   rsp_valid, rsp_result               one cycle strobe, no hold
// config       psel, penable, pwrite, paddr, ...   APB write, pready always 1
//
// One pixel enters every cycle; busy is never raised.
// Each accepted pixel passes through registers A, B, C to F, G, H and I.
// The depth is set by the four-stage restoring dividers for hue and
// saturation and by the multipliers of the HSL to RGB conversion.
// Reset is synchronous and clears the valid bits and the gain register.
module rgb_hsl_lightness_scaler_top (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    start,
   output logic                   busy,
   input  wire rhls_pkg::req_type req_pixel,
   output logic                   rsp_valid,
   output rhls_pkg::rsp_type      rsp_result,
   input  wire                    psel,
   input  wire                    penable,
   input  wire                    pwrite,
   input  wire  [1:0]             paddr,
   input  wire  [31:0]            pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);

   localparam int NS = rhls_pkg::DivStages;

   logic [15:0] gain_ff;

   // Configuration register at address zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= rhls_pkg::GainReset;
      end else if (psel && penable && pwrite && (paddr == rhls_pkg::CsrGain)) begin
         gain_ff <= pwdata[15:0];
      end
   end

   assign pready = 1'b1;
   assign prdata = {16'd0, gain_ff};
   assign busy   = 1'b0;

   // Stage A: capture the accepted transaction.
   logic              a_vld_ff;
   rhls_pkg::req_type a_pix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= start && !busy;
      end
      a_pix_ff <= req_pixel;
   end

   // Stage B: max, min, lightness and divider operands.
   logic              b_vld_ff, b_gray_ff;
   logic [11:0]       b_lit_ff;
   rhls_pkg::div_type b_hdiv_ff, b_sdiv_ff;
   logic              b_gray_in;
   logic [11:0]       b_lit_in;
   rhls_pkg::div_type b_hdiv_in, b_sdiv_in;

   always_comb begin
      logic [7:0]  r, g, b, mx, mn, d;
      logic [8:0]  sum, den;
      logic [11:0] y;
      logic [12:0] lit;
      logic signed [13:0] num;
      logic [23:0] hdvd, sdvd;
      logic [10:0] d6;
      r = a_pix_ff.in_red;
      g = a_pix_ff.in_green;
      b = a_pix_ff.in_blue;
      mx = r;
      mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      d   = mx - mn;
      sum = {1'b0, mx} + {1'b0, mn};
      den = (sum < 9'd255) ? sum : 9'd510 - sum;
      // Lightness sum*2048/255 as sum*8 plus sum*8/255.
      y   = {sum, 3'b000};
      lit = {1'b0, y} + {5'd0, 8'((({1'b0, y} + {9'd0, y[11:8]} + 13'd1) >> 8))};
      b_lit_in = (lit > 13'd4095) ? 12'd4095 : lit[11:0];
      // Hue numerator, shifted by 6d so that it is never negative.
      d6 = {3'd0, d} * 11'd6;
      if (r == mx) begin
         num = $signed({6'd0, g}) - $signed({6'd0, b});
      end else if (g == mx) begin
         num = $signed({5'd0, d, 1'b0}) + $signed({6'd0, b}) - $signed({6'd0, r});
      end else begin
         num = $signed({4'd0, d, 2'b00}) + $signed({6'd0, r}) - $signed({6'd0, g});
      end
      num  = num + $signed({3'd0, d6});
      hdvd = {num[11:0], 12'd0};
      sdvd = {4'd0, d, 12'd0};
      b_hdiv_in.rem = {3'd0, hdvd[23:16]};
      b_hdiv_in.shq = hdvd[15:0];
      b_hdiv_in.dvs = d6;
      b_sdiv_in.rem = {3'd0, sdvd[23:16]};
      b_sdiv_in.shq = sdvd[15:0];
      b_sdiv_in.dvs = {2'd0, den};
      b_gray_in = (d == 8'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else begin
         b_vld_ff <= a_vld_ff;
      end
      b_gray_ff <= b_gray_in;
      b_lit_ff  <= b_lit_in;
      b_hdiv_ff <= b_hdiv_in;
      b_sdiv_ff <= b_sdiv_in;
   end

   // Stages C to F: dividers, with valid, gray flag and scaled lightness alongside.
   rhls_pkg::div_type hdiv [NS+1];
   rhls_pkg::div_type sdiv [NS+1];
   logic [NS-1:0]     dv_vld_ff, dv_gray_ff;
   logic [11:0]       dv_sl_ff [NS];
   logic [11:0]       c_sl_in;

   assign hdiv[0] = b_hdiv_ff;
   assign sdiv[0] = b_sdiv_ff;

   for (genvar i = 0; i < NS; i++) begin : g_div
      rhls_div_stage u_hdiv (.clock(clock), .div_in(hdiv[i]), .div_out(hdiv[i+1]));
      rhls_div_stage u_sdiv (.clock(clock), .div_in(sdiv[i]), .div_out(sdiv[i+1]));
   end

   // Lightness gain with saturation at full scale.
   always_comb begin
      logic [27:0] prod;
      prod    = {16'd0, b_lit_ff} * {12'd0, gain_ff};
      c_sl_in = (prod[27:8] > 20'd4095) ? 12'd4095 : prod[19:8];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_vld_ff <= '0;
      end else begin
         dv_vld_ff <= {dv_vld_ff[NS-2:0], b_vld_ff};
      end
      dv_gray_ff <= {dv_gray_ff[NS-2:0], b_gray_ff};
      dv_sl_ff[0] <= c_sl_in;
      for (int i = 1; i < NS; i++) begin
         dv_sl_ff[i] <= dv_sl_ff[i-1];
      end
   end

   // Stage G: hue, saturation, q and the channel weights.
   logic        g_vld_ff;
   logic [11:0] g_hue_ff, g_sat_ff, g_sl_ff;
   logic [24:0] g_q_ff;
   logic [11:0] g_w_ff [3];
   logic [11:0] g_hue_in, g_sat_in;
   logic [24:0] g_q_in;
   logic [11:0] g_w_in [3];

   always_comb begin
      logic [15:0] sq;
      logic [11:0] sl;
      logic [14:0] h3, tr, tb;
      logic [24:0] lsat;
      sq = sdiv[NS].shq;
      sl = dv_sl_ff[NS-1];
      if (dv_gray_ff[NS-1]) begin
         g_hue_in = 12'd0;
         g_sat_in = 12'd0;
      end else begin
         g_hue_in = hdiv[NS].shq[11:0];
         g_sat_in = (sq > 16'd4095) ? 12'd4095 : sq[11:0];
      end
      lsat = {13'd0, sl} * {13'd0, g_sat_in};
      if (sl < 12'd2048) begin
         g_q_in = {13'd0, sl} * (25'd4096 + {13'd0, g_sat_in});
      end else begin
         g_q_in = {1'b0, sl, 12'd0} + {1'b0, g_sat_in, 12'd0} - lsat;
      end
      h3 = {3'd0, g_hue_in} * 15'd3;
      tr = h3 + rhls_pkg::HueThird;
      if (tr >= rhls_pkg::HueTurn3) tr = tr - rhls_pkg::HueTurn3;
      tb = (h3 >= rhls_pkg::HueThird) ? h3 - rhls_pkg::HueThird
                                      : h3 + rhls_pkg::HueTurn3 - rhls_pkg::HueThird;
      g_w_in[0] = rhls_pkg::ramp_weight(tr[13:0]);
      g_w_in[1] = rhls_pkg::ramp_weight(h3[13:0]);
      g_w_in[2] = rhls_pkg::ramp_weight(tb[13:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g_vld_ff <= 1'b0;
      end else begin
         g_vld_ff <= dv_vld_ff[NS-1];
      end
      g_hue_ff <= g_hue_in;
      g_sat_ff <= g_sat_in;
      g_sl_ff  <= dv_sl_ff[NS-1];
      g_q_ff   <= g_q_in;
      g_w_ff   <= g_w_in;
   end

   // Stage H: ramp numerators p*2048 + (q-p)*w for each channel.
   logic        h_vld_ff;
   logic [11:0] h_hue_ff, h_sat_ff, h_sl_ff;
   logic [35:0] h_num_ff [3];
   logic [35:0] h_num_in [3];

   always_comb begin
      logic [24:0] p, dq;
      logic [36:0] prod;
      p  = {g_sl_ff, 13'd0} - g_q_ff;
      dq = g_q_ff - p;
      for (int c = 0; c < 3; c++) begin
         prod = {12'd0, dq} * {25'd0, g_w_ff[c]};
         h_num_in[c] = {p, 11'd0} + prod[35:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_vld_ff <= 1'b0;
      end else begin
         h_vld_ff <= g_vld_ff;
      end
      h_hue_ff <= g_hue_ff;
      h_sat_ff <= g_sat_ff;
      h_sl_ff  <= g_sl_ff;
      h_num_ff <= h_num_in;
   end

   // Stage I: scale by 255, truncate and clamp; this is the result register.
   logic [7:0] i_ch_in [3];

   always_comb begin
      logic [43:0] x;
      for (int c = 0; c < 3; c++) begin
         x = {h_num_ff[c], 8'd0} - {8'd0, h_num_ff[c]};
         i_ch_in[c] = (x[43:35] > 9'd255) ? 8'd255 : x[42:35];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= h_vld_ff;
      end
      rsp_result.hue              <= h_hue_ff;
      rsp_result.saturation       <= h_sat_ff;
      rsp_result.scaled_lightness <= h_sl_ff;
      rsp_result.out_red          <= i_ch_in[0];
      rsp_result.out_green        <= i_ch_in[1];
      rsp_result.out_blue         <= i_ch_in[2];
   end

endmodule

`default_nettype wire

@@ src/rhls_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rhls_checker (
   input wire                    clock,
   input wire                    reset,
   input wire                    start,
   input wire                    busy,
   input wire rhls_pkg::req_type req_pixel,
   input wire                    rsp_valid,
   input wire rhls_pkg::rsp_type rsp_result,
   input wire                    psel,
   input wire                    penable,
   input wire                    pwrite,
   input wire  [1:0]             paddr,
   input wire  [31:0]            pwdata,
   input wire  [31:0]            prdata
);

   // Every accepted transaction yields a result once it has passed the full pipeline.
   a_latency : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##9 rsp_valid)
      else $error("missing result nine cycles after accept");

   // No result appears without a matching accepted transaction.
   a_no_extra : assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |-> ##9 !rsp_valid)
      else $error("result without a matching transaction");

   // Gray pixels give zero hue and saturation.
   a_gray : assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_pixel.in_red == req_pixel.in_green &&
       req_pixel.in_green == req_pixel.in_blue)
      |-> ##9 (rsp_result.hue == 12'd0 && rsp_result.saturation == 12'd0))
      else $error("gray pixel with nonzero hue or saturation");

   // A gain write is read back on the next cycle.
   a_gain_rb : assert property (@(posedge clock) disable iff (reset)
      (psel && penable && pwrite && paddr == rhls_pkg::CsrGain)
      |=> prdata[15:0] == $past(pwdata[15:0]))
      else $error("gain register readback mismatch");

   // Reset flushes the result strobe.
   a_reset : assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result strobe after reset");

endmodule

bind rgb_hsl_lightness_scaler_top rhls_checker u_rhls_checker (.*);

`default_nettype wire
